### rtl/core/compass_heading_calibrated_assert.svh
// assertion macros for the compass heading block
`ifndef COMPASS_HEADING_CALIBRATED_ASSERT_SVH
`define COMPASS_HEADING_CALIBRATED_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CHC_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define CHC_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define CHC_ASSERT_IMPL(label, a, c)
`define CHC_ASSERT_NEXT(label, a, c)
`endif
`endif

### rtl/core/chc_pkg.sv
`default_nettype none
package chc_pkg;
  localparam int ANG_LEN = 24;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_YSPAN = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic REQ_CAL = 1'b0;

  typedef struct packed {
    logic        ok;
    logic [1:0]  status;
    logic signed [17:0] x1;
    logic signed [33:0] y1;
  } job_t;

  function automatic logic [22:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 23'd2949120;
      5'd1: atan_lut = 23'd1740967;
      5'd2: atan_lut = 23'd919879;
      5'd3: atan_lut = 23'd466945;
      5'd4: atan_lut = 23'd234379;
      5'd5: atan_lut = 23'd117304;
      5'd6: atan_lut = 23'd58666;
      5'd7: atan_lut = 23'd29335;
      5'd8: atan_lut = 23'd14668;
      5'd9: atan_lut = 23'd7334;
      5'd10: atan_lut = 23'd3667;
      5'd11: atan_lut = 23'd1833;
      5'd12: atan_lut = 23'd917;
      5'd13: atan_lut = 23'd458;
      5'd14: atan_lut = 23'd229;
      5'd15: atan_lut = 23'd115;
      5'd16: atan_lut = 23'd57;
      5'd17: atan_lut = 23'd29;
      5'd18: atan_lut = 23'd14;
      5'd19: atan_lut = 23'd7;
      5'd20: atan_lut = 23'd4;
      5'd21: atan_lut = 23'd2;
      5'd22: atan_lut = 23'd1;
      default: atan_lut = 23'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

### rtl/core/chc_if.sv
`default_nettype none
interface chc_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  modport source (output valid, req_type, mag_x, mag_y, input ready);
  modport sink (input valid, req_type, mag_x, mag_y, output ready);
endinterface

interface chc_out_if;
  logic valid;
  logic ready;
  logic [12:0] heading;
  logic [2:0] sector;
  logic [1:0] status;
  modport source (output valid, heading, sector, status, input ready);
  modport sink (input valid, heading, sector, status, output ready);
endinterface
`default_nettype wire

### rtl/core/chc_front.sv
`default_nettype none
// calibration tracking, scale division and centering; emits one job per heading request
module chc_front (
  input  wire logic clk,
  input  wire logic rst,
  chc_in_if.sink    in_ch,
  output chc_pkg::job_t job,
  output logic      job_valid,
  input  wire logic job_ready
);
  import chc_pkg::*;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001, F_PREP = 6'b000010, F_DIV = 6'b000100,
    F_MUL = 6'b001000, F_CLAMP = 6'b010000, F_OUT = 6'b100000
  } fstate_t;

  fstate_t state;
  logic signed [15:0] x_max, x_min, y_max, y_min, mx, my;
  logic signed [16:0] xbias, ybias;
  logic [15:0] dx, dy, half;
  logic [34:0] rem;
  logic [18:0] quo;
  logic [4:0] cnt;
  logic [17:0] scale;
  logic signed [18:0] cx, cy;
  logic signed [37:0] prod;
  logic signed [17:0] x1c;
  job_t jr;

  logic signed [16:0] sx, sy;
  logic [35:0] rem_sh;
  logic [19:0] rem_diff;
  logic q_bit;
  logic [34:0] rem_next;
  logic signed [37:0] lim;
  logic signed [18:0] hl;

  assign sx = 17'(x_max) + 17'(x_min);
  assign sy = 17'(y_max) + 17'(y_min);
  // remainder sits above the dividend bits still to be shifted in
  assign rem_sh = {rem, 1'b0};
  assign q_bit = rem_sh[35:16] >= {4'd0, dy};
  assign rem_diff = rem_sh[35:16] - {4'd0, dy};
  assign rem_next = q_bit ? {rem_diff[18:0], rem_sh[15:0]} : rem_sh[34:0];
  assign lim = 38'(half) <<< 16;
  assign hl = 19'(half);

  assign in_ch.ready = (state == F_IDLE);
  assign job = jr;
  assign job_valid = (state == F_OUT) && !jr.ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      x_max <= '0; x_min <= '0; y_max <= '0; y_min <= '0;
    end else begin
      unique case (state)
        F_IDLE: if (in_ch.valid) begin
          mx <= in_ch.mag_x; my <= in_ch.mag_y;
          if (in_ch.req_type == REQ_CAL) begin
            if (in_ch.mag_x > x_max) x_max <= in_ch.mag_x;
            if (in_ch.mag_y > y_max) y_max <= in_ch.mag_y;
            if (in_ch.mag_x < x_min) x_min <= in_ch.mag_x;
            if (in_ch.mag_y < y_min) y_min <= in_ch.mag_y;
          end else state <= F_PREP;
        end
        F_PREP: begin
          // truncate toward zero
          xbias <= $signed(sx + 17'(sx[16])) >>> 1;
          ybias <= $signed(sy + 17'(sy[16])) >>> 1;
          dx <= 16'(17'(x_max) - 17'(x_min));
          dy <= 16'(17'(y_max) - 17'(y_min));
          half <= 16'((17'(x_max) - 17'(x_min)) >> 1);
          rem <= {19'd0, 16'(17'(x_max) - 17'(x_min))};
          quo <= '0; cnt <= '0;
          state <= F_DIV;
        end
        F_DIV: begin
          if (dy == 16'd0) begin
            jr <= '{ok: 1'b0, status: ST_YSPAN, x1: '0, y1: '0};
            state <= F_OUT;
          end else begin
            // restoring division of dx<<16 by dy, one quotient bit per cycle;
            // top quotient bit is sticky so overflow still saturates
            rem <= rem_next;
            quo <= {quo[18] | quo[17], quo[16:0], q_bit};
            if (cnt == 5'd31) begin
              state <= F_MUL;
            end
            cnt <= cnt + 5'd1;
          end
        end
        F_MUL: begin
          scale <= (quo > 19'h3FFFF) ? 18'h3FFFF : quo[17:0];
          cx <= 19'(mx) - 19'(xbias);
          cy <= 19'(my) - 19'(ybias);
          state <= F_CLAMP;
        end
        F_CLAMP: begin
          prod <= $signed({1'b0, scale}) * cy;
          x1c <= (cx > hl) ? 18'(hl) : (cx < -hl) ? 18'(-hl) : 18'(cx);
          state <= F_OUT;
          if (scale == 18'd0)
            jr <= '{ok: 1'b0, status: ST_ZERO, x1: '0, y1: '0};
          else jr.ok <= 1'b1;
        end
        F_OUT: begin
          if (jr.ok) begin
            jr.ok <= 1'b0;
            jr.x1 <= x1c;
            jr.y1 <= (prod > lim) ? 34'(lim) : (prod < -lim) ? 34'(-lim) : 34'(prod);
            jr.status <= ST_OK;
            if (x1c == 0 && ((prod > lim) ? lim : (prod < -lim) ? -lim : prod) == 0)
              jr.status <= ST_ZERO;
            state <= F_OUT;
          end else if (job_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/chc_queue.sv
`default_nettype none
// two-entry job queue between front and back
module chc_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  chc_pkg::job_t wdata,
  input  wire logic wvalid,
  output logic      wready,
  output chc_pkg::job_t rdata,
  output logic      rvalid,
  input  wire logic rready
);
  import chc_pkg::*;
  job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic wr, rd;
  assign wready = cnt != 2'd2;
  assign rvalid = cnt != 2'd0;
  assign rdata = mem[rp];
  assign wr = wvalid && wready;
  assign rd = rvalid && rready;
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr) begin mem[wp] <= wdata; wp <= ~wp; end
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

### rtl/core/chc_back.sv
`default_nettype none
// vectoring cordic and heading / sector formatting
module chc_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  chc_pkg::job_t job,
  input  wire logic job_valid,
  output logic      job_ready,
  chc_out_if.source out_ch
);
  import chc_pkg::*;
  `include "compass_heading_calibrated_assert.svh"

  localparam int STEPS = (CORDIC_STEPS < ANG_LEN) ? CORDIC_STEPS : ANG_LEN;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001, B_ITER = 4'b0010, B_FIN = 4'b0100, B_OUT = 4'b1000
  } bstate_t;

  bstate_t state;
  logic signed [36:0] x, y;
  logic signed [27:0] ang;
  logic [4:0] i;
  logic [12:0] h_r;
  logic [2:0] s_r;
  logic [1:0] st_r;

  logic signed [36:0] xs, ys, jx, jy;
  logic signed [27:0] a2, af;
  logic [15:0] hr;
  logic [12:0] hm;

  // 45-degree sectors centered on each direction, north wraps around
  function automatic logic [2:0] sector_of(input logic [12:0] h);
    if (h < 13'd360) return 3'd0;
    if (h < 13'd1080) return 3'd1;
    if (h < 13'd1800) return 3'd2;
    if (h < 13'd2520) return 3'd3;
    if (h < 13'd3240) return 3'd4;
    if (h < 13'd3960) return 3'd5;
    if (h < 13'd4680) return 3'd6;
    if (h < 13'd5400) return 3'd7;
    return 3'd0;
  endfunction

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign jx = 37'(job.x1) <<< 16;
  assign jy = 37'(job.y1);
  assign a2 = ang + 28'sd11796480;
  assign af = a2[27] ? 28'sd0 : a2;
  assign hr = 16'((af + 28'sd2048) >>> 12);
  assign hm = (hr >= 16'd5760) ? 13'(hr - 16'd5760) : 13'(hr);

  assign job_ready = (state == B_IDLE);
  assign out_ch.valid = (state == B_OUT);
  assign out_ch.heading = h_r;
  assign out_ch.sector = s_r;
  assign out_ch.status = st_r;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else begin
      unique case (state)
        B_IDLE: if (job_valid) begin
          st_r <= job.status;
          i <= '0;
          if (job.status != ST_OK) begin
            h_r <= '0; s_r <= '0; state <= B_OUT;
          end else begin
            if (jx < 0) begin
              x <= -jx; y <= -jy;
              ang <= (jy >= 0) ? 28'sd11796480 : -28'sd11796480;
            end else begin
              x <= jx; y <= jy; ang <= '0;
            end
            state <= B_ITER;
          end
        end
        B_ITER: begin
          if (y > 0) begin
            x <= x + ys; y <= y - xs; ang <= ang + 28'(atan_lut(i));
          end else begin
            x <= x - ys; y <= y + xs; ang <= ang - 28'(atan_lut(i));
          end
          if (32'(i) == STEPS - 1) state <= B_FIN;
          i <= i + 5'd1;
        end
        B_FIN: begin
          h_r <= hm;
          s_r <= sector_of(hm);
          state <= B_OUT;
        end
        B_OUT: if (out_ch.ready) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  `CHC_ASSERT_IMPL(a_hdg_range, out_ch.valid, out_ch.heading < 13'd5760)
  `CHC_ASSERT_IMPL(a_bad_zero, out_ch.valid && out_ch.status != ST_OK, out_ch.heading == 13'd0)
  `CHC_ASSERT_NEXT(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(h_r))
endmodule
`default_nettype wire

### rtl/core/compass_heading_calibrated.sv
// compass_heading_calibrated: hard-iron calibrated compass heading
// in_ch carries requests: req_type 0 is a calibration sample that widens
// the running x/y min and max and gives no result; req_type 1 is a heading
// request that yields one result on out_ch (heading in 1/16 degree,
// 8-way sector, status).
// flow: the front end takes a calibration request in its idle state; a heading
// request passes the front end (prepare, the x-span/y-span scale divider at one
// quotient bit per cycle, scale and centering, product and clamp, output)
// before its job enters the queue, then the back end runs the vectoring CORDIC,
// one rotation per cycle, and formats heading and sector.
// the front end takes a new request only after its last job is in the queue;
// the two-entry queue lets front and back overlap.
// reset: rst (synchronous) clears min/max state to zero and empties all
// stages.
// a stalled receiver holds the result; the queue fills and then the front
// end stops taking requests.
`default_nettype none
module compass_heading_calibrated #(
  parameter int CORDIC_STEPS = 16
) (
  input wire logic clk,
  input wire logic rst,
  chc_in_if.sink   in_ch,
  chc_out_if.source out_ch
);
  import chc_pkg::*;
  job_t fj, qj;
  logic fv, fr, qv, qr;

  // front: calibration and normalization
  chc_front u_front (.clk, .rst, .in_ch, .job(fj), .job_valid(fv), .job_ready(fr));
  // queue decouples divider from cordic
  chc_queue u_queue (.clk, .rst, .wdata(fj), .wvalid(fv), .wready(fr),
                     .rdata(qj), .rvalid(qv), .rready(qr));
  // back: angle computation
  chc_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (.clk, .rst, .job(qj),
      .job_valid(qv), .job_ready(qr), .out_ch);
endmodule
`default_nettype wire

### tb/sv/compass_heading_checker.sv
`default_nettype none
module compass_heading_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input wire logic clk,
  input wire logic rst,
  chc_in_if        in_ch,
  chc_out_if       out_ch,
  output int       errors,
  output int       pending
);
  import chc_pkg::*;

  typedef struct {
    logic [12:0] heading;
    logic [2:0]  sector;
    logic [1:0]  status;
  } bearing_t;

  localparam longint DEG = 65536;
  localparam longint ATAN_DEG [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  longint   x_hi, x_lo, y_hi, y_lo;
  bearing_t bearings_due[$];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bearing_t bearing_of(input longint mx, input longint my);
    bearing_t b;
    longint xoff, yoff, xspan, yspan, scale, half, xc, yc, x, y, ang, xs, ys, a, h;
    b.heading = '0;
    b.sector = '0;
    xoff = (x_hi + x_lo) / 2;
    yoff = (y_hi + y_lo) / 2;
    xspan = x_hi - x_lo;
    yspan = y_hi - y_lo;
    if (yspan == 0) begin
      b.status = ST_YSPAN;
      return b;
    end
    scale = (xspan * DEG) / yspan;
    if (scale > 64'h3FFFF) scale = 64'h3FFFF;
    if (scale == 0) begin
      b.status = ST_ZERO;
      return b;
    end
    half = xspan / 2;
    xc = mx - xoff;
    if (xc > half) xc = half;
    if (xc < -half) xc = -half;
    x = xc * DEG;
    yc = scale * (my - yoff);
    if (yc > half * DEG) yc = half * DEG;
    if (yc < -half * DEG) yc = -half * DEG;
    y = yc;
    if (x == 0 && y == 0) begin
      b.status = ST_ZERO;
      return b;
    end
    // vectoring cordic, left half plane folded over first
    ang = 0;
    if (x < 0) begin
      ang = (y >= 0) ? 180 * DEG : -180 * DEG;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; ang += ATAN_DEG[i];
      end else begin
        x = x - ys; y = y + xs; ang -= ATAN_DEG[i];
      end
    end
    a = ang + 180 * DEG;
    if (a < 0) a = 0;
    h = ((a + 2048) >>> 12) % 5760;
    b.heading = h[12:0];
    b.sector = ((h + 360) / 720) % 8;
    b.status = ST_OK;
    return b;
  endfunction

  assign pending = bearings_due.size();

  always @(posedge clk) begin
    bearing_t want;
    if (rst) begin
      x_hi <= 0; x_lo <= 0; y_hi <= 0; y_lo <= 0;
      bearings_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.req_type == REQ_CAL) begin
          if (longint'(in_ch.mag_x) > x_hi) x_hi <= in_ch.mag_x;
          if (longint'(in_ch.mag_x) < x_lo) x_lo <= in_ch.mag_x;
          if (longint'(in_ch.mag_y) > y_hi) y_hi <= in_ch.mag_y;
          if (longint'(in_ch.mag_y) < y_lo) y_lo <= in_ch.mag_y;
        end else begin
          bearings_due.push_back(bearing_of(in_ch.mag_x, in_ch.mag_y));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (bearings_due.size() == 0) begin
          report("unexpected result count", 1, 0);
        end else begin
          want = bearings_due.pop_front();
          if (out_ch.heading !== want.heading) report("heading", out_ch.heading, want.heading);
          if (out_ch.sector !== want.sector) report("sector", out_ch.sector, want.sector);
          if (out_ch.status !== want.status) report("status", out_ch.status, want.status);
        end
      end
    end
  end

  initial errors = 0;
endmodule
`default_nettype wire

### tb/sv/compass_heading_calibrated_tb.sv
`default_nettype none
module compass_heading_calibrated_tb;
  import chc_pkg::*;

  // heading request code, the package only names the calibration one
  localparam logic REQ_HEADING = ~REQ_CAL;
  localparam int STUCK_LIMIT = 4000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   idle_cycles;
  int   stall_mode;

  chc_in_if  in_ch ();
  chc_out_if out_ch ();

  compass_heading_calibrated dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  compass_heading_checker chk (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one; mode 0 means no idling at all
  function automatic int gap_len(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stall: ready held low for gaps drawn the same way
  int stall_left;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= gap_len(stall_mode);
    end
  end

  // watchdog: too long without any request or result accepted
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("[compass_heading_calibrated] ERROR");
      $finish;
    end
  end

  // drive one request from a falling edge, hold until taken, then maybe idle
  task automatic send(input logic kind, input logic signed [15:0] x,
                      input logic signed [15:0] y, input int mode);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.mag_x <= x;
    in_ch.mag_y <= y;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    gap = gap_len(mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic signed [15:0] near(input int lim);
    return 16'($signed($urandom_range(0, 2 * lim)) - lim);
  endfunction

  // random mix of calibration and heading requests, noise values in range lim
  task automatic random_run(input int count, input int cal_lim, input int head_lim);
    int mode;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        mode = $urandom_range(0, 3);
        stall_mode = $urandom_range(0, 3);
      end
      if ($urandom_range(0, 99) < 30)
        send(REQ_CAL, near(cal_lim), near(cal_lim), mode);
      else
        send(REQ_HEADING, near(head_lim), near(head_lim), mode);
    end
  endtask

  initial begin
    rst = 1'b1;
    idle_cycles = 0;
    stall_mode = 1;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_CAL;
    in_ch.mag_x = '0;
    in_ch.mag_y = '0;
    out_ch.ready = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // state still all zero: y span zero
    send(REQ_HEADING, 16'sd100, -16'sd100, 1);
    // only y widened: x span zero gives zero scale
    send(REQ_CAL, 16'sd0, 16'sd5, 1);
    send(REQ_HEADING, 16'sd3, 16'sd1, 1);
    // x span 10 against y span 5
    send(REQ_CAL, 16'sd10, 16'sd0, 1);
    send(REQ_HEADING, 16'sd5, 16'sd2, 1);     // dead center, zero vector
    send(REQ_HEADING, 16'sd0, 16'sd2, 1);     // due west side, 360 wraps to 0
    send(REQ_HEADING, 16'sd10, 16'sd2, 1);
    send(REQ_HEADING, 16'sd5, 16'sd5, 1);
    send(REQ_HEADING, 16'sd5, 16'sd0, 1);
    send(REQ_HEADING, 16'sd9, 16'sd4, 1);
    send(REQ_HEADING, 16'sd1, 16'sd0, 1);
    send(REQ_HEADING, -16'sd32768, 16'sd32767, 1);
    send(REQ_HEADING, 16'sd32767, -16'sd32768, 1);
    // x span 40 over y span 5: scale saturates
    send(REQ_CAL, 16'sd40, 16'sd3, 1);
    send(REQ_HEADING, 16'sd30, 16'sd4, 1);
    send(REQ_HEADING, 16'sd12, 16'sd1, 1);
    send(REQ_HEADING, -16'sd1, -16'sd1, 1);

    // small spans first, since the min/max only ever widen
    random_run(700, 300, 400);

    // full scale extremes of both axes
    send(REQ_CAL, 16'sd32767, 16'sd32767, 1);
    send(REQ_HEADING, 16'sd0, 16'sd0, 1);
    send(REQ_CAL, -16'sd32768, -16'sd32768, 1);
    send(REQ_HEADING, 16'sd32767, 16'sd32767, 1);
    send(REQ_HEADING, -16'sd32768, -16'sd32768, 1);
    send(REQ_HEADING, -16'sd32768, 16'sd0, 1);

    random_run(820, 32768, 32768);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0)
      $display("[compass_heading_calibrated] OK");
    else
      $display("[compass_heading_calibrated] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
